@@ design/rpi_pkg.sv @@
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types, codes and helpers of the ray / primitive intersection block.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 8;
  localparam logic [15:0] EPS_RESET = 16'd7;

  // primitive kinds as they arrive on the ray channel
  typedef enum logic [1:0] {
    OP_SPHERE   = 2'd0,
    OP_PLANE    = 2'd1,
    OP_CYLINDER = 2'd2,
    OP_CONE     = 2'd3
  } op_t;

  // what the back end has to do with a queued job
  typedef enum logic {
    JOB_QUAD,
    JOB_SINGLE
  } job_kind_t;

  // quadratic job: a, h, c; single root job: h is numerator, a is divisor
  typedef struct packed {
    job_kind_t          kind;
    logic [15:0]        tag;
    logic signed [63:0] a;
    logic signed [63:0] h;
    logic signed [63:0] c;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DISC,
    BK_SQRT,
    BK_DIV,
    BK_SAT,
    BK_OUT
  } back_state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? 64'(n) : 64'(v);
  endfunction

endpackage

@@ design/rpi_intf.sv @@
// ----------------------------------------------------------------------------
// rpi channel interfaces
// Ray input, hit output and epsilon write channels, valid / ready handshake.
// ----------------------------------------------------------------------------
interface rpi_ray_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [15:0]        object_tag;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [31:0] centre_z;

  modport source (output valid, operation, object_tag, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, centre_x, centre_y, centre_z, input ready);
  modport sink (input valid, operation, object_tag, origin_x, origin_y, origin_z,
                dir_x, dir_y, dir_z, centre_x, centre_y, centre_z, output ready);
endinterface

interface rpi_hit_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hit_distance;
  logic [15:0]        hit_tag;
  logic               last_hit;

  modport source (output valid, hit_distance, hit_tag, last_hit, input ready);
  modport sink (input valid, hit_distance, hit_tag, last_hit, output ready);
endinterface

interface rpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] epsilon;

  modport source (output valid, epsilon, input ready);
  modport sink (input valid, epsilon, output ready);
endinterface

@@ design/ray_primitive_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_primitive_intersect
// Ray against sphere, plane, cylinder or double cone, signed fixed point.
// ----------------------------------------------------------------------------
// Rays enter a three-stage front end that forms a, h and c and drops rays that
// cannot hit; the front takes a ray every cycle while the job queue has room.
// The back end solves one job at a time on a shared sequencer: a quadratic
// runs the partial product multiply, the discriminant, the 64-step square root
// and two bit-serial divisions of 64 + FRAC_BITS steps, each followed by
// saturation; a plane or degenerate cone root runs one division. Hit words
// leave through an output register, so the back end starts the next job while
// the last hit waits to be taken. Epsilon resets to 7; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module ray_primitive_intersect import rpi_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  rpi_ray_if.sink   ray,
  rpi_hit_if.source hit,
  rpi_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]      epsilon;
  logic             push, pop, q_valid;
  job_t             push_job, q_job;
  logic [CNT_W-1:0] q_count;

  // epsilon register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg.valid) begin
      epsilon <= cfg.epsilon;
    end
  end

  rpi_front #(
    .FRAC_BITS   (FRAC_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .ray      (ray),
    .epsilon  (epsilon),
    .q_count  (q_count),
    .push     (push),
    .push_job (push_job)
  );

  rpi_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_count  (q_count)
  );

  rpi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .hit     (hit)
  );

endmodule

@@ design/rpi_front.sv @@
// ----------------------------------------------------------------------------
// rpi_front
// Accepts rays, forms the quadric coefficients in a short pipeline and
// classifies each ray into a quadratic job, a single root job or no hit.
// ----------------------------------------------------------------------------
module rpi_front import rpi_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  rpi_ray_if.sink          ray,
  input  logic [15:0]      epsilon,
  input  logic [CNT_W-1:0] q_count,
  output logic             push,
  output job_t             push_job
);

  localparam logic signed [63:0] ONE = 64'(1) << FRAC_BITS;

  // stage 1: operands
  logic               s1_valid;
  op_t                s1_op;
  logic [15:0]        s1_tag;
  logic signed [31:0] s1_d [3];
  logic signed [32:0] s1_v [3];
  logic signed [31:0] s1_oy;

  // stage 2: products
  logic               s2_valid;
  op_t                s2_op;
  logic [15:0]        s2_tag;
  logic signed [63:0] s2_pa [3];
  logic signed [64:0] s2_ph [3];
  logic signed [65:0] s2_pc [3];
  logic signed [31:0] s2_oy;
  logic signed [31:0] s2_dy;

  // stage 3: coefficients
  logic               s3_valid;
  op_t                s3_op;
  logic [15:0]        s3_tag;
  logic signed [63:0] s3_a;
  logic signed [63:0] s3_h;
  logic signed [63:0] s3_c;
  logic signed [31:0] s3_oy;
  logic signed [31:0] s3_dy;

  logic [CNT_W:0] occupancy;
  logic           accept;

  // room for every ray in flight plus those queued
  assign occupancy = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_valid)
                   + (CNT_W + 1)'(s2_valid) + (CNT_W + 1)'(s3_valid);
  assign ray.ready = occupancy < (CNT_W + 1)'(QUEUE_DEPTH);
  assign accept    = ray.valid && ray.ready;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage 1: offset from the centre for the sphere
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op_t'(ray.operation);
      s1_tag  <= ray.object_tag;
      s1_d[0] <= ray.dir_x;
      s1_d[1] <= ray.dir_y;
      s1_d[2] <= ray.dir_z;
      s1_oy   <= ray.origin_y;
      if (op_t'(ray.operation) == OP_SPHERE) begin
        s1_v[0] <= 33'(ray.origin_x) - 33'(ray.centre_x);
        s1_v[1] <= 33'(ray.origin_y) - 33'(ray.centre_y);
        s1_v[2] <= 33'(ray.origin_z) - 33'(ray.centre_z);
      end else begin
        s1_v[0] <= 33'(ray.origin_x);
        s1_v[1] <= 33'(ray.origin_y);
        s1_v[2] <= 33'(ray.origin_z);
      end
    end
  end

  // stage 2: one product per multiplier
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_pa[i] <= s1_d[i] * s1_d[i];
      s2_ph[i] <= s1_d[i] * s1_v[i];
      s2_pc[i] <= s1_v[i] * s1_v[i];
    end
    s2_op  <= s1_op;
    s2_tag <= s1_tag;
    s2_oy  <= s1_oy;
    s2_dy  <= s1_d[1];
  end

  // stage 3: sums, y term weighted by kind, floor to fixed point
  logic signed [67:0] ya, yh, yc, sa, sh, sc;

  always_comb begin
    ya = 68'(s2_pa[1]);
    yh = 68'(s2_ph[1]);
    yc = 68'(s2_pc[1]);
    case (s2_op)
      OP_CYLINDER: begin
        ya = '0;
        yh = '0;
        yc = '0;
      end
      OP_CONE: begin
        ya = -ya;
        yh = -yh;
        yc = -yc;
      end
      default: ;
    endcase
    sa = 68'(s2_pa[0]) + ya + 68'(s2_pa[2]);
    sh = 68'(s2_ph[0]) + yh + 68'(s2_ph[2]);
    sc = 68'(s2_pc[0]) + yc + 68'(s2_pc[2]);
  end

  always_ff @(posedge clk) begin
    s3_a <= 64'(sa >>> FRAC_BITS);
    s3_h <= 64'(sh >>> FRAC_BITS);
    if (s2_op == OP_SPHERE || s2_op == OP_CYLINDER) begin
      s3_c <= 64'(sc >>> FRAC_BITS) - ONE;
    end else begin
      s3_c <= 64'(sc >>> FRAC_BITS);
    end
    s3_op  <= s2_op;
    s3_tag <= s2_tag;
    s3_oy  <= s2_oy;
    s3_dy  <= s2_dy;
  end

  // classify: drop rays that cannot hit, pick single root or quadratic
  logic [63:0]        eps64;
  logic signed [63:0] dy64, b64;
  logic               keep;

  assign eps64 = 64'(epsilon);
  assign dy64  = 64'(s3_dy);
  assign b64   = s3_h <<< 1;

  always_comb begin
    keep          = 1'b0;
    push_job.kind = JOB_QUAD;
    push_job.tag  = s3_tag;
    push_job.a    = s3_a;
    push_job.h    = s3_h;
    push_job.c    = s3_c;
    unique case (s3_op)
      OP_SPHERE: begin
        keep = s3_a > 0;
      end
      OP_PLANE: begin
        keep          = (dy64 != 0) && (mag64(dy64) >= eps64);
        push_job.kind = JOB_SINGLE;
        push_job.a    = dy64;
        push_job.h    = -64'(s3_oy);
      end
      OP_CYLINDER: begin
        keep = (s3_a != 0) && (mag64(s3_a) >= eps64);
      end
      OP_CONE: begin
        if ((s3_a != 0) && (mag64(s3_a) >= eps64)) begin
          keep = 1'b1;
        end else begin
          keep          = (b64 != 0) && (mag64(b64) >= eps64);
          push_job.kind = JOB_SINGLE;
          push_job.a    = b64;
          push_job.h    = -s3_c;
        end
      end
      default: ;
    endcase
  end

  assign push = s3_valid && keep;

endmodule

@@ design/rpi_queue.sv @@
// ----------------------------------------------------------------------------
// rpi_queue
// Short first-in first-out job queue between the front and back ends.
// ----------------------------------------------------------------------------
module rpi_queue import rpi_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  job_t             push_job,
  input  logic             pop,
  output logic             q_valid,
  output job_t             q_job,
  output logic [CNT_W-1:0] q_count
);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_valid = count != '0;
  assign q_job   = slots[rd_ptr];
  assign q_count = count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  // front end credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(QUEUE_DEPTH)) || pop)
    else $error("job queue overflow");

  // pops only come from a nonempty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("job queue underflow");

  // fill count stays within the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("job queue count out of range");
`endif

endmodule

@@ design/rpi_back.sv @@
// ----------------------------------------------------------------------------
// rpi_back
// Solves queued jobs: discriminant by partial products, digit-by-digit square
// root, bit-serial saturating divider, then emits the ordered hit words.
// ----------------------------------------------------------------------------
module rpi_back import rpi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
  localparam int DIV_W    = 64 + FRAC_BITS,
  localparam int CNT_W    = $clog2(DIV_W)
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      pop,
  rpi_hit_if.source hit
);

  back_state_t state, state_next;

  job_kind_t          kind;
  logic [15:0]        tag;
  logic signed [63:0] ja, jh, jc;
  logic [CNT_W-1:0]   cnt;

  logic [127:0] hh_acc, ac_acc, rad;
  logic [65:0]  rem;
  logic [63:0]  root;

  logic [DIV_W-1:0] dvd, quo;
  logic [63:0]      rmd, dmag;
  logic             dneg, second;

  logic signed [31:0] t1, res0, res1;
  logic               two_res, oidx;

  logic               ov, olast;
  logic signed [31:0] odist;
  logic [15:0]        otag;

  assign hit.valid        = ov;
  assign hit.hit_distance = odist;
  assign hit.hit_tag      = otag;
  assign hit.last_hit     = olast;

  logic out_load;
  assign out_load = (state == BK_OUT) && (!ov || hit.ready);

  // partial product step: |h|*|h| then |a|*|c|, 32x32 each
  logic [63:0]  mh, ma, mc, opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [1:0]   kk;

  always_comb begin
    mh    = mag64(jh);
    ma    = mag64(ja);
    mc    = mag64(jc);
    kk    = cnt[1:0];
    opa   = cnt[2] ? ma : mh;
    opb   = cnt[2] ? mc : mh;
    pp    = (kk[1] ? opa[63:32] : opa[31:0]) * (kk[0] ? opb[63:32] : opb[31:0]);
    pp_sh = 128'(pp);
    case (kk)
      2'd1, 2'd2: pp_sh = 128'(pp) << 32;
      2'd3:       pp_sh = 128'(pp) << 64;
      default:    ;
    endcase
  end

  // discriminant h*h - a*c
  logic [127:0] disc;
  logic         ac_neg;
  assign ac_neg = ja[63] ^ jc[63];
  assign disc   = ac_neg ? hh_acc + ac_acc : hh_acc - ac_acc;

  // square root digit step
  logic [67:0] sq_rem4, sq_trial;
  logic        sq_take;
  logic [63:0] root_next;
  assign sq_rem4   = {rem, rad[127:126]};
  assign sq_trial  = {2'b00, root, 2'b01};
  assign sq_take   = sq_rem4 >= sq_trial;
  assign root_next = {root[62:0], sq_take};

  // divider operands for the next division
  logic signed [63:0] s_root, s_root_next, dl_num, dl_den;
  assign s_root      = $signed(root);
  assign s_root_next = $signed(root_next);

  always_comb begin
    if (state == BK_IDLE) begin
      dl_num = q_job.h;
      dl_den = q_job.a;
    end else if (state == BK_SQRT) begin
      // last root digit lands in the same cycle, so take it from the step
      dl_num = -jh - s_root_next;
      dl_den = ja;
    end else begin
      dl_num = -jh + s_root;
      dl_den = ja;
    end
  end

  // divider bit step
  logic [64:0] dv_r2;
  logic        dv_take;
  assign dv_r2   = {rmd, dvd[DIV_W-1]};
  assign dv_take = dv_r2 >= {1'b0, dmag};

  // saturation of the finished quotient
  logic signed [31:0] qsat;
  always_comb begin
    if (!dneg) begin
      qsat = (quo > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end else begin
      qsat = (quo > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_job.kind == JOB_QUAD) ? BK_MUL : BK_DIV;
        end
      end
      BK_MUL: begin
        if (cnt == CNT_W'(7)) begin
          state_next = BK_DISC;
        end
      end
      BK_DISC: begin
        state_next = disc[127] ? BK_IDLE : BK_SQRT;
      end
      BK_SQRT: begin
        if (cnt == CNT_W'(63)) begin
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt == CNT_W'(DIV_W - 1)) begin
          state_next = BK_SAT;
        end
      end
      BK_SAT: begin
        state_next = (kind == JOB_QUAD && !second) ? BK_DIV : BK_OUT;
      end
      BK_OUT: begin
        if (out_load && (!two_res || oidx)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop = (state == BK_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        ov <= 1'b1;
      end else if (hit.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt <= cnt + 1'b1;
    case (state)
      BK_IDLE: begin
        kind    <= q_job.kind;
        tag     <= q_job.tag;
        ja      <= q_job.a;
        jh      <= q_job.h;
        jc      <= q_job.c;
        cnt     <= '0;
        hh_acc  <= '0;
        ac_acc  <= '0;
        second  <= 1'b0;
        oidx    <= 1'b0;
        dneg    <= dl_num[63] ^ dl_den[63];
        dvd     <= DIV_W'(mag64(dl_num)) << FRAC_BITS;
        dmag    <= mag64(dl_den);
        rmd     <= '0;
      end
      BK_MUL: begin
        if (cnt[2]) begin
          ac_acc <= ac_acc + pp_sh;
        end else begin
          hh_acc <= hh_acc + pp_sh;
        end
      end
      BK_DISC: begin
        rad  <= disc;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      BK_SQRT: begin
        rad  <= rad << 2;
        rem  <= sq_take ? 66'(sq_rem4 - sq_trial) : 66'(sq_rem4);
        root <= root_next;
        if (cnt == CNT_W'(63)) begin
          cnt  <= '0;
          dneg <= dl_num[63] ^ dl_den[63];
          dvd  <= DIV_W'(mag64(dl_num)) << FRAC_BITS;
          dmag <= mag64(dl_den);
          rmd  <= '0;
        end
      end
      BK_DIV: begin
        dvd <= dvd << 1;
        quo <= {quo[DIV_W-2:0], dv_take};
        rmd <= dv_take ? 64'(dv_r2 - {1'b0, dmag}) : dv_r2[63:0];
      end
      BK_SAT: begin
        cnt <= '0;
        if (kind == JOB_SINGLE) begin
          res0    <= qsat;
          two_res <= 1'b0;
        end else if (!second) begin
          t1     <= qsat;
          second <= 1'b1;
          dneg   <= dl_num[63] ^ dl_den[63];
          dvd    <= DIV_W'(mag64(dl_num)) << FRAC_BITS;
          dmag   <= mag64(dl_den);
          rmd    <= '0;
        end else begin
          two_res <= 1'b1;
          if (qsat < t1) begin
            res0 <= qsat;
            res1 <= t1;
          end else begin
            res0 <= t1;
            res1 <= qsat;
          end
        end
      end
      BK_OUT: begin
        if (out_load) begin
          odist <= oidx ? res1 : res0;
          otag  <= tag;
          olast <= !two_res || oidx;
          oidx  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // a job only reaches the divider with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (dmag != '0))
    else $error("divide by zero in back end");

  // square root remainder never exceeds twice the partial root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SQRT) |-> (rem <= {1'b0, root, 1'b0}))
    else $error("square root remainder out of range");

  // two roots leave nearer first
  a_root_order: assert property (@(posedge clk) disable iff (rst)
    (state == BK_OUT && two_res) |-> (res0 <= res1))
    else $error("roots out of order");
`endif

endmodule

@@ tb/rpi_tb_types.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpi testbench types
// Ray and hit word layouts shared by the stimulus and the scoreboard.
// ----------------------------------------------------------------------------
package rpi_tb_types;
  import rpi_pkg::*;

  // one ray word as driven on the input channel
  typedef struct {
    op_t                op;
    logic [15:0]        tag;
    logic signed [31:0] o [3];
    logic signed [31:0] d [3];
    logic signed [31:0] c [3];
  } ray_word_t;

  // one hit word as expected on the output channel
  typedef struct {
    logic signed [31:0] distance;
    logic [15:0]        tag;
    logic               last;
  } hit_word_t;

  // directed row: fixed_hits < 0 means the hit model decides
  typedef struct {
    ray_word_t          ray;
    int                 fixed_hits;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
  } ray_row_t;
endpackage

@@ tb/ray_primitive_intersect_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_primitive_intersect_tb
// Drives directed and random rays against every primitive kind, predicts the
// hit words in fixed point and checks each one in order, under several
// epsilon settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module ray_primitive_intersect_tb;
  import rpi_pkg::*;
  import rpi_tb_types::*;

  localparam int FRAC = 16;
  localparam int ONE = 1 << FRAC;
  localparam int N_PHASES = 5;
  localparam int RAYS_PER_PHASE = 366;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;
  rpi_ray_if ray_ch ();
  rpi_hit_if hit_ch ();
  rpi_cfg_if cfg_ch ();

  ray_primitive_intersect u_top (
    .clk (clk),
    .rst (rst),
    .ray (ray_ch.sink),
    .hit (hit_ch.source),
    .cfg (cfg_ch.sink)
  );

  hit_word_t   pending_hits [$];
  ray_row_t    directed_rows [$];
  logic [15:0] eps_model;
  int          ray_idle_pct;
  int          hit_idle_pct;
  int          hold_cycles;
  int          errors;
  int          rays_sent;
  int          hits_seen;
  longint      cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d hits still pending", cycle_count,
                 pending_hits.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- hit model
  function automatic logic signed [63:0] floor_q(input logic signed [127:0] s);
    return 64'(s >>> FRAC);
  endfunction

  // num * 2^F / den toward zero, saturated to 32 bits
  function automatic logic signed [31:0] sat_quot(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
    logic [127:0] mn;
    logic [127:0] md;
    logic [127:0] q;
    logic         neg;
    mn = num[63] ? 128'(-num) : 128'(num);
    md = den[63] ? 128'(-den) : 128'(den);
    mn = num[63] ? (~128'(unsigned'(num)) + 128'd1) & {64'd0, {64{1'b1}}} : mn;
    md = den[63] ? (~128'(unsigned'(den)) + 128'd1) & {64'd0, {64{1'b1}}} : md;
    neg = num[63] ^ den[63];
    q = (mn << FRAC) / md;
    if (!neg) return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
    return (q > 128'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] x);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 62; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= x) r = c;
    end
    return r[63:0];
  endfunction

  function automatic void push_hit(input logic signed [31:0] t, input logic [15:0] tag,
                                   input logic last);
    hit_word_t w;
    w.distance = t;
    w.tag = tag;
    w.last = last;
    pending_hits.push_back(w);
  endfunction

  function automatic void solve_quadric(input logic signed [63:0] a,
                                        input logic signed [63:0] h,
                                        input logic signed [63:0] c,
                                        input logic [15:0] tag);
    logic signed [127:0] disc;
    logic signed [63:0]  s;
    logic signed [31:0]  t1;
    logic signed [31:0]  t2;
    logic signed [31:0]  tmp;
    disc = 128'(h) * 128'(h) - 128'(a) * 128'(c);
    if (disc < 0) return;
    s = root_floor(disc);
    t1 = sat_quot(-h - s, a);
    t2 = sat_quot(-h + s, a);
    if (t2 < t1) begin
      tmp = t1;
      t1 = t2;
      t2 = tmp;
    end
    push_hit(t1, tag, 1'b0);
    push_hit(t2, tag, 1'b1);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic void predict_hits(input ray_word_t r);
    logic signed [63:0]  ox, oy, oz, dx, dy, dz, px, py, pz, a, h, c, b;
    logic signed [127:0] sa, sh, sc;
    ox = r.o[0]; oy = r.o[1]; oz = r.o[2];
    dx = r.d[0]; dy = r.d[1]; dz = r.d[2];
    case (r.op)
      OP_SPHERE: begin
        px = ox - 64'(r.c[0]);
        py = oy - 64'(r.c[1]);
        pz = oz - 64'(r.c[2]);
        sa = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
        sh = 128'(dx) * 128'(px) + 128'(dy) * 128'(py) + 128'(dz) * 128'(pz);
        sc = 128'(px) * 128'(px) + 128'(py) * 128'(py) + 128'(pz) * 128'(pz);
        a = floor_q(sa);
        h = floor_q(sh);
        c = floor_q(sc) - ONE;
        if (a > 0) solve_quadric(a, h, c, r.tag);
      end
      OP_PLANE: begin
        if (dy != 0 && abs64(dy) >= 64'(eps_model))
          push_hit(sat_quot(-oy, dy), r.tag, 1'b1);
      end
      OP_CYLINDER: begin
        a = floor_q(128'(dx) * 128'(dx) + 128'(dz) * 128'(dz));
        h = floor_q(128'(ox) * 128'(dx) + 128'(oz) * 128'(dz));
        c = floor_q(128'(ox) * 128'(ox) + 128'(oz) * 128'(oz)) - ONE;
        if (a != 0 && abs64(a) >= 64'(eps_model)) solve_quadric(a, h, c, r.tag);
      end
      default: begin
        a = floor_q(128'(dx) * 128'(dx) - 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz));
        h = floor_q(128'(ox) * 128'(dx) - 128'(oy) * 128'(dy) + 128'(oz) * 128'(dz));
        c = floor_q(128'(ox) * 128'(ox) - 128'(oy) * 128'(oy) + 128'(oz) * 128'(oz));
        // degenerate cone falls back to the linear root
        if (a == 0 || abs64(a) < 64'(eps_model)) begin
          b = 2 * h;
          if (b != 0 && abs64(b) >= 64'(eps_model))
            push_hit(sat_quot(-c, b), r.tag, 1'b1);
        end else begin
          solve_quadric(a, h, c, r.tag);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] near_val(input int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic ray_word_t random_ray();
    ray_word_t r;
    int        kind;
    r.op = op_t'($urandom_range(0, 3));
    r.tag = 16'($urandom);
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 70) begin
        // scene-sized rays that mostly hit something
        r.o[i] = near_val(4 * ONE);
        r.d[i] = near_val(2 * ONE);
        r.c[i] = near_val(2 * ONE);
      end else if (kind < 85) begin
        r.o[i] = $urandom;
        r.d[i] = $urandom;
        r.c[i] = $urandom;
      end else begin
        // axis-aligned or nearly degenerate directions
        r.o[i] = near_val(3 * ONE);
        r.d[i] = ($urandom_range(0, 1) == 1) ? near_val(16) : near_val(ONE);
        r.c[i] = near_val(ONE);
      end
    end
    return r;
  endfunction

  function automatic void add_row(input op_t op, input logic [15:0] tag,
                                  input int ox, input int oy, input int oz,
                                  input int dx, input int dy, input int dz,
                                  input int cx, input int cy, input int cz,
                                  input int nfix, input int t0, input int t1);
    ray_row_t row;
    row.ray.op = op;
    row.ray.tag = tag;
    row.ray.o = '{ox, oy, oz};
    row.ray.d = '{dx, dy, dz};
    row.ray.c = '{cx, cy, cz};
    row.fixed_hits = nfix;
    row.t0 = t0;
    row.t1 = t1;
    directed_rows.push_back(row);
  endfunction

  task automatic send_ray(input ray_word_t r, input int nfix,
                          input logic signed [31:0] t0, input logic signed [31:0] t1);
    if ($urandom_range(0, 99) < ray_idle_pct) begin
      ray_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.operation <= r.op;
    ray_ch.object_tag <= r.tag;
    ray_ch.origin_x <= r.o[0];
    ray_ch.origin_y <= r.o[1];
    ray_ch.origin_z <= r.o[2];
    ray_ch.dir_x <= r.d[0];
    ray_ch.dir_y <= r.d[1];
    ray_ch.dir_z <= r.d[2];
    ray_ch.centre_x <= r.c[0];
    ray_ch.centre_y <= r.c[1];
    ray_ch.centre_z <= r.c[2];
    do @(posedge clk); while (!ray_ch.ready);
    rays_sent++;
    if (nfix < 0) begin
      predict_hits(r);
    end else if (nfix == 1) begin
      push_hit(t0, r.tag, 1'b1);
    end else if (nfix == 2) begin
      push_hit(t0, r.tag, 1'b0);
      push_hit(t1, r.tag, 1'b1);
    end
  endtask

  task automatic drain();
    ray_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.epsilon <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    eps_model = v;
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      hit_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hit_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      hit_ch.ready <= ($urandom_range(0, 99) >= hit_idle_pct);
    end
  end

  // compare each accepted hit word with the oldest prediction
  always @(posedge clk) begin
    hit_word_t w;
    if (!rst && hit_ch.valid && hit_ch.ready) begin
      hits_seen++;
      if (pending_hits.size() == 0) begin
        $display("%0t unexpected hit: distance %h tag %h last %b", $time,
                 hit_ch.hit_distance, hit_ch.hit_tag, hit_ch.last_hit);
        errors++;
      end else begin
        w = pending_hits.pop_front();
        if (w.distance !== hit_ch.hit_distance) begin
          $display("%0t hit_distance expected %h actual %h", $time, w.distance,
                   hit_ch.hit_distance);
          errors++;
        end
        if (w.tag !== hit_ch.hit_tag) begin
          $display("%0t hit_tag expected %h actual %h", $time, w.tag, hit_ch.hit_tag);
          errors++;
        end
        if (w.last !== hit_ch.last_hit) begin
          $display("%0t last_hit expected %b actual %b", $time, w.last, hit_ch.last_hit);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    logic [15:0] eps_set [N_PHASES];
    ray_row_t    row;
    errors = 0;
    rays_sent = 0;
    hits_seen = 0;
    hold_cycles = 0;
    ray_idle_pct = 25;
    hit_idle_pct = 58;
    eps_model = EPS_RESET;
    rst = 1'b1;
    ray_ch.valid = 1'b0;
    ray_ch.operation = OP_SPHERE;
    ray_ch.object_tag = '0;
    ray_ch.origin_x = '0;
    ray_ch.origin_y = '0;
    ray_ch.origin_z = '0;
    ray_ch.dir_x = '0;
    ray_ch.dir_y = '0;
    ray_ch.dir_z = '0;
    ray_ch.centre_x = '0;
    ray_ch.centre_y = '0;
    ray_ch.centre_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.epsilon = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sphere straight through the centre, double root, miss, zero direction, extremes, tiny direction
    add_row(OP_SPHERE, 16'h0001, 0, 0, -3 * ONE, 0, 0, ONE, 0, 0, 0, 2, 2 * ONE, 4 * ONE);
    add_row(OP_SPHERE, 16'h0002, 0, ONE, -3 * ONE, 0, 0, ONE, 0, 0, 0, 2, 3 * ONE,
            3 * ONE);
    add_row(OP_SPHERE, 16'h0003, 0, 5 * ONE, -3 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
    add_row(OP_SPHERE, 16'h0004, ONE, 2, 3, 0, 0, 0, 4, 5, 6, 0, 0, 0);
    add_row(OP_SPHERE, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            -1, 0, 0);
    add_row(OP_SPHERE, 16'h0000, -ONE, ONE, 0, 1, -1, 1, ONE, -ONE, 0, -1, 0, 0);
    // plane: unit hit, small divisor below epsilon, zero divisor, saturation
    add_row(OP_PLANE, 16'h0010, 0, -ONE, 0, 0, ONE, 0, 0, 0, 0, 1, ONE, 0);
    add_row(OP_PLANE, 16'h0011, 0, -ONE, 0, 0, 5, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PLANE, 16'h0012, 0, -ONE, 0, ONE, 0, ONE, 0, 0, 0, 0, 0, 0);
    add_row(OP_PLANE, 16'h0013, 0, 32'h80000000, 0, 0, 7, 0, 0, 0, 0, 1, 32'h7FFFFFFF, 0);
    add_row(OP_PLANE, 16'h0014, 0, 32'h7FFFFFFF, 0, 0, 7, 0, 0, 0, 0, 1, 32'h80000000, 0);
    add_row(OP_PLANE, 16'h0015, 0, 32'h80000000, 0, 0, 32'h80000000, 0, 0, 0, 0, -1, 0, 0);
    // cylinder: through the axis, along the axis, extremes, from inside
    add_row(OP_CYLINDER, 16'h0020, -3 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 2, 2 * ONE, 4 * ONE);
    add_row(OP_CYLINDER, 16'h0021, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_CYLINDER, 16'h0022, 32'h7FFFFFFF, 0, 32'h80000000, 32'h80000000, 3,
            32'h7FFFFFFF, 0, 0, 0, -1, 0, 0);
    add_row(OP_CYLINDER, 16'h0023, ONE / 2, 0, 0, ONE, 0, 0, 0, 0, 0, -1, 0, 0);
    // cone: degenerate linear root, degenerate with no root, a negative, a positive, extremes
    add_row(OP_CONE, 16'h0030, ONE, 0, 0, ONE, ONE, 0, 0, 0, 0, 1, -ONE / 2, 0);
    add_row(OP_CONE, 16'h0031, 0, 0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_CONE, 16'h0032, ONE, 2 * ONE, 0, 0, ONE, 0, 0, 0, 0, -1, 0, 0);
    add_row(OP_CONE, 16'h0033, 0, ONE, 2 * ONE, ONE, 0, ONE, 0, 0, 0, -1, 0, 0);
    add_row(OP_CONE, 16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
            32'h80000000, 32'h7FFFFFFF, 0, 0, 0, -1, 0, 0);

    // directed rays at the reset epsilon
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_ray(row.ray, row.fixed_hits, row.t0, row.t1);
    end
    drain();

    eps_set = '{16'd7, 16'd0, 16'hFFFF, 16'd1000, 16'($urandom)};
    for (int p = 0; p < N_PHASES; p++) begin
      // idling: receiver-heavy, then sender-heavy, then none
      case (p % 3)
        0: begin
          ray_idle_pct = 25;
          hit_idle_pct = 58;
        end
        1: begin
          ray_idle_pct = 58;
          hit_idle_pct = 25;
        end
        default: begin
          ray_idle_pct = 0;
          hit_idle_pct = 0;
        end
      endcase
      if (p != 0) write_epsilon(eps_set[p]);
      // long receiver stall so the job queue backs up into the ray channel
      if (p == 2) hold_cycles <= 3000;
      for (int k = 0; k < RAYS_PER_PHASE; k++) send_ray(random_ray(), -1, 0, 0);
      drain();
    end

    $display("rays sent %0d, hits checked %0d, all four primitive kinds", rays_sent,
             hits_seen);
    $display("epsilon settings 7, 0, 65535, 1000 and one random value, mixed idling");
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
